/* hw/rtl/sactp_pkg.sv */
package sactp_pkg;

    localparam int MAX_SETS    = 1024;
    localparam int MAX_WAYS    = 16;
    localparam int BLOCK_BYTES = 64;

    localparam int ADDR_W  = 48;
    localparam int BLK_SH  = $clog2(BLOCK_BYTES);
    localparam int TAG_W   = ADDR_W - BLK_SH;
    localparam int SET_W   = $clog2(MAX_SETS);
    localparam int WAY_W   = $clog2(MAX_WAYS);
    localparam int CNT_W   = 32;
    localparam int WAYS_CW = 5;
    localparam int SETS_CW = 11;
    localparam int DIV_CW  = $clog2(TAG_W + 1);

    // register indexes
    localparam logic [1:0] REG_REPLACE = 2'd0;
    localparam logic [1:0] REG_WRITE   = 2'd1;
    localparam logic [1:0] REG_WAYS    = 2'd2;
    localparam logic [1:0] REG_SETS    = 2'd3;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
    } t_cmd;

    typedef struct packed {
        logic             hit;
        logic             fill_read;
        logic [1:0]       memory_writes;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] read_total;
        logic [CNT_W-1:0] write_total;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef t_entry [MAX_WAYS-1:0] t_row;

endpackage

/* hw/rtl/set_assoc_cache_tag_policy.sv */
// Tag store and replacement control of a set-associative cache (64-byte
// blocks, up to 1024 sets of up to 16 ways, LRU or FIFO, write-through or
// write-back). A transaction is taken when start is high and busy is low;
// one result comes back on o_result with o_valid high for a single cycle and
// must be captured then, since the receiver cannot stall it. A transaction
// first computes the set index in a one bit per cycle remainder unit, then
// reads the set row, compares one way per cycle until a match or the last
// of the configured ways (1..16), and finally writes the row back and
// reports. After reset a clearing pass writes all 1024 set rows, one per
// cycle, while busy stays high; configuration writes are taken at any time
// over the APB port.
module set_assoc_cache_tag_policy (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sactp_pkg::t_cmd    i_cmd,
    output logic               o_valid,
    output sactp_pkg::t_result o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_READ, S_SEARCH, S_UPDATE
    } t_state;

    // ---------------- configuration registers ----------------
    logic                            r_replace;
    logic                            r_wpol;
    logic [sactp_pkg::WAYS_CW-1:0]   r_ways;
    logic [sactp_pkg::SETS_CW-1:0]   r_sets;
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replace <= 1'b0;
            r_wpol    <= 1'b1;
            r_ways    <= sactp_pkg::WAYS_CW'(4);
            r_sets    <= sactp_pkg::SETS_CW'(128);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                sactp_pkg::REG_REPLACE: r_replace <= pwdata[0];
                sactp_pkg::REG_WRITE:   r_wpol    <= pwdata[0];
                sactp_pkg::REG_WAYS:    r_ways    <= pwdata[sactp_pkg::WAYS_CW-1:0];
                sactp_pkg::REG_SETS:    r_sets    <= pwdata[sactp_pkg::SETS_CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sactp_pkg::REG_REPLACE: prdata = {31'd0, r_replace};
            sactp_pkg::REG_WRITE:   prdata = {31'd0, r_wpol};
            sactp_pkg::REG_WAYS:    prdata = 32'(r_ways);
            sactp_pkg::REG_SETS:    prdata = 32'(r_sets);
            default:                prdata = '0;
        endcase
    end

    // Effective geometry: zero acts as one, oversize clamps to the maximum.
    logic [sactp_pkg::WAYS_CW-1:0] ways_eff;
    logic [sactp_pkg::SETS_CW-1:0] sets_eff;
    logic [sactp_pkg::WAY_W-1:0]   last_way;

    always_comb begin
        if (r_ways == '0) ways_eff = sactp_pkg::WAYS_CW'(1);
        else if (r_ways > sactp_pkg::WAYS_CW'(sactp_pkg::MAX_WAYS))
            ways_eff = sactp_pkg::WAYS_CW'(sactp_pkg::MAX_WAYS);
        else ways_eff = r_ways;
        if (r_sets == '0) sets_eff = sactp_pkg::SETS_CW'(1);
        else if (r_sets > sactp_pkg::SETS_CW'(sactp_pkg::MAX_SETS))
            sets_eff = sactp_pkg::SETS_CW'(sactp_pkg::MAX_SETS);
        else sets_eff = r_sets;
    end

    assign last_way = sactp_pkg::WAY_W'(ways_eff - 1'b1);

    // ---------------- sequencer state ----------------
    t_state                        r_state;
    logic                          r_act;
    logic [sactp_pkg::TAG_W-1:0]   r_block;
    logic [sactp_pkg::SET_W-1:0]   r_set;
    logic [sactp_pkg::SET_W-1:0]   r_clr;
    logic [sactp_pkg::WAY_W-1:0]   r_way;
    logic                          r_hit;
    logic                          r_valid;
    sactp_pkg::t_result            r_result;
    logic [sactp_pkg::CNT_W-1:0]   r_hits, r_misses, r_reads, r_writes;

    logic                          accept;
    logic                          div_done;
    logic [sactp_pkg::SET_W-1:0]   div_rem;
    logic [sactp_pkg::TAG_W-1:0]   cmd_block;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign cmd_block = i_cmd.address[sactp_pkg::ADDR_W-1:sactp_pkg::BLK_SH];

    sactp_divmod u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (cmd_block),
        .i_divisor  (sets_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // ---------------- set row memory ----------------
    sactp_pkg::t_row             mem [sactp_pkg::MAX_SETS];
    sactp_pkg::t_row             r_row;
    sactp_pkg::t_row             new_row;
    logic                        mem_we;
    logic [sactp_pkg::SET_W-1:0] mem_waddr;
    sactp_pkg::t_row             mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (r_state == S_READ) r_row <= mem[r_set];
    end

    always_comb begin
        mem_we    = (r_state == S_CLEAR) || (r_state == S_UPDATE);
        mem_waddr = (r_state == S_CLEAR) ? r_clr : r_set;
        mem_wdata = (r_state == S_CLEAR) ? sactp_pkg::t_row'('0) : new_row;
    end

    // ---------------- single-way compare ----------------
    logic way_match;
    assign way_match = r_row[r_way].valid && (r_row[r_way].tag == r_block);

    // ---------------- row update ----------------
    logic                        wb_write;
    logic                        do_shift;
    logic [sactp_pkg::WAY_W-1:0] pos;
    logic                        victim_dirty;
    logic                        wt_write;
    logic [1:0]                  mw;

    always_comb begin
        wb_write     = r_wpol && (r_act == sactp_pkg::ACT_WRITE);
        wt_write     = !r_wpol && (r_act == sactp_pkg::ACT_WRITE);
        do_shift     = !r_hit || !r_replace;
        pos          = r_hit ? r_way : last_way;
        victim_dirty = !r_hit && r_row[last_way].valid && r_row[last_way].dirty;
        mw           = 2'(victim_dirty) + 2'(wt_write);
        for (int j = 0; j < sactp_pkg::MAX_WAYS; j++) begin
            new_row[j] = r_row[j];
            if (do_shift && j == 0) begin
                new_row[j].valid = 1'b1;
                new_row[j].tag   = r_block;
                new_row[j].dirty = r_hit ? (r_row[r_way].dirty || wb_write) : wb_write;
            end else if (do_shift && sactp_pkg::WAY_W'(j) <= pos) begin
                new_row[j] = r_row[(j == 0) ? 0 : j - 1];
            end else if (r_hit && !do_shift && sactp_pkg::WAY_W'(j) == r_way) begin
                new_row[j].dirty = r_row[j].dirty || wb_write;
            end
        end
    end

    function automatic logic [sactp_pkg::CNT_W-1:0] sat_add(
        input logic [sactp_pkg::CNT_W-1:0] a, input logic [1:0] b);
        logic [sactp_pkg::CNT_W:0] s;
        s = {1'b0, a} + (sactp_pkg::CNT_W+1)'(b);
        return s[sactp_pkg::CNT_W] ? '1 : s[sactp_pkg::CNT_W-1:0];
    endfunction

    logic [sactp_pkg::CNT_W-1:0] nx_hits, nx_misses, nx_reads, nx_writes;
    always_comb begin
        nx_hits   = sat_add(r_hits, 2'(r_hit));
        nx_misses = sat_add(r_misses, 2'(!r_hit));
        nx_reads  = sat_add(r_reads, 2'(!r_hit));
        nx_writes = sat_add(r_writes, mw);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_valid  <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
            r_reads  <= '0;
            r_writes <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == sactp_pkg::SET_W'(sactp_pkg::MAX_SETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_act   <= i_cmd.action;
                        r_block <= cmd_block;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_set   <= div_rem;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_way   <= '0;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (way_match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_UPDATE;
                    end else if (r_way == last_way) begin
                        r_hit   <= 1'b0;
                        r_state <= S_UPDATE;
                    end else begin
                        r_way <= r_way + 1'b1;
                    end
                end
                S_UPDATE: begin
                    r_hits   <= nx_hits;
                    r_misses <= nx_misses;
                    r_reads  <= nx_reads;
                    r_writes <= nx_writes;
                    r_valid  <= 1'b1;
                    r_result <= '{hit: r_hit, fill_read: !r_hit, memory_writes: mw,
                                  hit_total: nx_hits, miss_total: nx_misses,
                                  read_total: nx_reads, write_total: nx_writes};
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // ---------------- assertions ----------------
    a_fill_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.fill_read != o_result.hit))
        else $error("fill_read must be the inverse of hit");

    a_hit_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.hit) |-> (o_result.memory_writes != 2'd2))
        else $error("a hit cannot evict a dirty victim");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block must go busy after a transaction is taken");

    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_UPDATE))
        else $error("result strobe without a row update");

endmodule

/* hw/rtl/sactp_divmod.sv */
// Restoring remainder unit, one dividend bit per cycle.
module sactp_divmod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sactp_pkg::TAG_W-1:0]  i_dividend,
    input  logic [sactp_pkg::SETS_CW-1:0] i_divisor,
    output logic                         o_done,
    output logic [sactp_pkg::SET_W-1:0]  o_rem
);

    logic [sactp_pkg::TAG_W-1:0]   r_dvd;
    logic [sactp_pkg::SET_W-1:0]   r_rem;
    logic [sactp_pkg::DIV_CW-1:0]  r_cnt;
    logic                          r_done;
    logic [sactp_pkg::SETS_CW-1:0] shifted;
    logic                          ge;

    assign shifted = {r_rem, r_dvd[sactp_pkg::TAG_W-1]};
    assign ge      = (shifted >= i_divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd <= i_dividend;
                r_rem <= '0;
                r_cnt <= sactp_pkg::DIV_CW'(sactp_pkg::TAG_W);
            end else if (r_cnt != '0) begin
                r_dvd <= {r_dvd[sactp_pkg::TAG_W-2:0], 1'b0};
                r_rem <= ge ? sactp_pkg::SET_W'(shifted - i_divisor)
                            : shifted[sactp_pkg::SET_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                r_done <= (r_cnt == sactp_pkg::DIV_CW'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
